@@ rtl/mds_pkg.sv @@
// Shared constants, codes and item types for the multi-deque store.
package mds_pkg;

    localparam int NUM_DEQUES = 16;
    localparam int DEPTH      = 64;

    localparam int ID_W      = (NUM_DEQUES > 1) ? $clog2(NUM_DEQUES) : 1;
    localparam int SLOT_W    = $clog2(DEPTH);
    localparam int SUM_W     = SLOT_W + 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int NF_W      = $clog2(NUM_DEQUES + 1);
    localparam int ADDR_W    = ID_W + SLOT_W;
    localparam int MEM_DEPTH = NUM_DEQUES * (2 ** SLOT_W);

    localparam int OPC_W  = 3;
    localparam int DID_W  = 4;
    localparam int VAL_W  = 64;
    localparam int STAT_W = 3;

    localparam logic [OPC_W-1:0] OP_CREATE     = 3'd0;
    localparam logic [OPC_W-1:0] OP_COPY       = 3'd1;
    localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 3'd3;
    localparam logic [OPC_W-1:0] OP_POP_FRONT  = 3'd4;
    localparam logic [OPC_W-1:0] OP_POP_BACK   = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_ID = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_ID  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd4;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [DID_W-1:0] deque_id;
        logic [VAL_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  pop_value;
        logic [DID_W-1:0]  new_id;
        logic              now_empty;
    } out_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [CNT_W-1:0]  count;
    } dir_entry_t;

endpackage

@@ rtl/mds_slot_unit.sv @@
// Shared ring-slot adder: slot = (base + off) wrapped once at DEPTH.
module mds_slot_unit (
    input  logic [mds_pkg::SLOT_W-1:0] base,
    input  logic [mds_pkg::SUM_W-1:0]  off,
    output logic [mds_pkg::SLOT_W-1:0] slot
);
    import mds_pkg::*;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;

    assign sum     = SUM_W'(base) + off;
    assign wrapped = sum - SUM_W'(DEPTH);

    // base < DEPTH and off < DEPTH keep the sum below twice DEPTH
    assign slot = (sum >= SUM_W'(DEPTH)) ? wrapped[SLOT_W-1:0] : sum[SLOT_W-1:0];

endmodule

@@ rtl/multi_deque_store.sv @@
// Top level of the multi-deque store: sequencer, directory, entry memory, result register.
//
//   channel  dir  handshake           payload
//   s_*      in   s_valid / s_ready   s_item : opcode, deque_id, push_value
//   m_*      out  m_valid / m_ready   m_item : status, pop_value, new_id, now_empty
//
// Create, push, pop and rejected items pass the idle, directory and done states;
// copy adds a read state and a write state per source entry between directory
// and done; the single read port of the entry memory and the shared slot adder
// set this (one read and one write per entry). The result register is loaded
// from the done state, which waits while the output register is still full.
// s_ready is high only in the idle state; a result waiting in the output
// register does not block the next accept, only the next result load.
// Reset (aresetn, synchronous) frees all ids at once; no clearing pass, since
// directory entries are rewritten on allocation and entries on push.
module multi_deque_store (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mds_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output mds_pkg::out_item_t m_item
);
    import mds_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIR   = 5'b00010,
        S_CP_RD = 5'b00100,
        S_CP_WR = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    // Sequencer and control registers
    state_t                  state_reg, state_next;
    in_item_t                item_reg, item_next;
    logic [NUM_DEQUES-1:0]   alloc_reg, alloc_next;
    logic [NF_W-1:0]         next_free_reg, next_free_next;
    logic [CNT_W-1:0]        idx_cnt_reg, idx_cnt_next;
    logic [ID_W-1:0]         dst_reg, dst_next;
    logic [STAT_W-1:0]       res_status_reg, res_status_next;
    logic [DID_W-1:0]        res_id_reg, res_id_next;
    logic                    res_empty_reg, res_empty_next;
    logic                    pop_sel_reg, pop_sel_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_item_reg, m_item_next;

    // Directory memory: head and count per deque, valid only when allocated
    dir_entry_t              dir_mem [NUM_DEQUES];
    dir_entry_t              dir_q_reg;
    logic                    dir_re, dir_we;
    logic [ID_W-1:0]         dir_raddr, dir_waddr;
    dir_entry_t              dir_wdata;

    // Entry memory: one ring of 2**SLOT_W slots per deque
    logic [VAL_W-1:0]        entry_mem [MEM_DEPTH];
    logic [VAL_W-1:0]        mem_q_reg;
    logic                    mem_re, mem_we;
    logic [ADDR_W-1:0]       mem_raddr, mem_waddr;
    logic [VAL_W-1:0]        mem_wdata;

    // Shared slot adder
    logic [SUM_W-1:0]        unit_off;
    logic [SLOT_W-1:0]       unit_slot;

    logic [ID_W-1:0]         src_idx;
    logic [ID_W-1:0]         new_idx;
    logic                    in_range;
    logic                    src_ok;
    logic                    ids_left;
    logic                    is_full;
    logic                    is_front;
    logic                    out_free;

    mds_slot_unit u_slot (
        .base (dir_q_reg.head),
        .off  (unit_off),
        .slot (unit_slot)
    );

    assign src_idx  = ID_W'(item_reg.deque_id);
    assign new_idx  = ID_W'(next_free_reg);
    assign in_range = int'(item_reg.deque_id) < NUM_DEQUES;
    assign src_ok   = in_range && alloc_reg[src_idx];
    assign ids_left = next_free_reg != NF_W'(NUM_DEQUES);
    assign is_full  = dir_q_reg.count == CNT_W'(DEPTH);
    assign is_front = (item_reg.opcode == OP_PUSH_FRONT) || (item_reg.opcode == OP_POP_FRONT);
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Pick the slot adder offset for the current step
    always_comb begin
        unit_off = SUM_W'(dir_q_reg.count);
        case (state_reg)
            S_CP_RD: begin
                unit_off = SUM_W'(idx_cnt_reg);
            end
            S_DIR: begin
                case (item_reg.opcode)
                    OP_PUSH_FRONT: unit_off = SUM_W'(DEPTH - 1);
                    OP_PUSH_BACK:  unit_off = SUM_W'(dir_q_reg.count);
                    OP_POP_FRONT:  unit_off = SUM_W'(1);
                    OP_POP_BACK:   unit_off = SUM_W'(dir_q_reg.count) - SUM_W'(1);
                    default:       unit_off = SUM_W'(dir_q_reg.count);
                endcase
            end
            default: begin
                unit_off = SUM_W'(dir_q_reg.count);
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        alloc_next      = alloc_reg;
        next_free_next  = next_free_reg;
        idx_cnt_next    = idx_cnt_reg;
        dst_next        = dst_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_empty_next  = res_empty_reg;
        pop_sel_next    = pop_sel_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;

        dir_re    = 1'b0;
        dir_raddr = ID_W'(s_item.deque_id);
        dir_we    = 1'b0;
        dir_waddr = src_idx;
        dir_wdata = dir_q_reg;

        mem_re    = 1'b0;
        mem_raddr = {src_idx, unit_slot};
        mem_we    = 1'b0;
        mem_waddr = {src_idx, unit_slot};
        mem_wdata = item_reg.push_value;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_item;
                    dir_re     = 1'b1;
                    state_next = S_DIR;
                end
            end

            S_DIR: begin
                res_status_next = STAT_BAD_ID;
                res_id_next     = '0;
                res_empty_next  = 1'b0;
                pop_sel_next    = 1'b0;
                state_next      = S_DONE;
                case (item_reg.opcode)
                    OP_CREATE: begin
                        if (ids_left) begin
                            alloc_next[new_idx] = 1'b1;
                            next_free_next      = next_free_reg + NF_W'(1);
                            dir_we              = 1'b1;
                            dir_waddr           = new_idx;
                            dir_wdata           = '0;
                            res_status_next     = STAT_OK;
                            res_id_next         = DID_W'(next_free_reg);
                            res_empty_next      = 1'b1;
                        end else begin
                            res_status_next = STAT_NO_ID;
                        end
                    end
                    OP_COPY: begin
                        if (!src_ok) begin
                            res_status_next = STAT_BAD_ID;
                        end else if (!ids_left) begin
                            res_status_next = STAT_NO_ID;
                        end else begin
                            alloc_next[new_idx] = 1'b1;
                            next_free_next      = next_free_reg + NF_W'(1);
                            dir_we              = 1'b1;
                            dir_waddr           = new_idx;
                            dir_wdata.head      = '0;
                            dir_wdata.count     = dir_q_reg.count;
                            dst_next            = new_idx;
                            idx_cnt_next        = '0;
                            res_status_next     = STAT_OK;
                            res_id_next         = DID_W'(next_free_reg);
                            res_empty_next      = dir_q_reg.count == '0;
                            // walk the source front to back, one read state and one write state per entry
                            if (dir_q_reg.count != '0) begin
                                state_next = S_CP_RD;
                            end
                        end
                    end
                    OP_PUSH_FRONT, OP_PUSH_BACK: begin
                        if (!src_ok) begin
                            res_status_next = STAT_BAD_ID;
                        end else if (is_full) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            mem_we          = 1'b1;
                            mem_waddr       = {src_idx, unit_slot};
                            dir_we          = 1'b1;
                            dir_waddr       = src_idx;
                            dir_wdata.head  = is_front ? unit_slot : dir_q_reg.head;
                            dir_wdata.count = dir_q_reg.count + CNT_W'(1);
                            res_status_next = STAT_OK;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (!src_ok) begin
                            res_status_next = STAT_BAD_ID;
                        end else if (dir_q_reg.count == '0) begin
                            res_status_next = STAT_EMPTY;
                            res_empty_next  = 1'b1;
                        end else begin
                            mem_re          = 1'b1;
                            mem_raddr       = {src_idx, is_front ? dir_q_reg.head : unit_slot};
                            dir_we          = 1'b1;
                            dir_waddr       = src_idx;
                            dir_wdata.head  = is_front ? unit_slot : dir_q_reg.head;
                            dir_wdata.count = dir_q_reg.count - CNT_W'(1);
                            res_status_next = STAT_OK;
                            res_empty_next  = dir_q_reg.count == CNT_W'(1);
                            pop_sel_next    = 1'b1;
                        end
                    end
                    default: begin
                        res_status_next = STAT_BAD_ID;
                    end
                endcase
            end

            S_CP_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = {src_idx, unit_slot};
                state_next = S_CP_WR;
            end

            S_CP_WR: begin
                mem_we       = 1'b1;
                mem_waddr    = {dst_reg, idx_cnt_reg[SLOT_W-1:0]};
                mem_wdata    = mem_q_reg;
                idx_cnt_next = idx_cnt_reg + CNT_W'(1);
                if (idx_cnt_reg == dir_q_reg.count - CNT_W'(1)) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_CP_RD;
                end
            end

            S_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    m_item_next.status    = res_status_reg;
                    m_item_next.pop_value = pop_sel_reg ? mem_q_reg : '0;
                    m_item_next.new_id    = res_id_reg;
                    m_item_next.now_empty = res_empty_reg;
                    m_valid_next          = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            alloc_reg     <= '0;
            next_free_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            alloc_reg     <= alloc_next;
            next_free_reg <= next_free_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        idx_cnt_reg    <= idx_cnt_next;
        dst_reg        <= dst_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_empty_reg  <= res_empty_next;
        pop_sel_reg    <= pop_sel_next;
        m_item_reg     <= m_item_next;
    end

    // Directory memory
    always_ff @(posedge aclk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re) begin
            dir_q_reg <= dir_mem[dir_raddr];
        end
    end

    // Entry memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg <= entry_mem[mem_raddr];
        end
    end

endmodule
